// File: src/grz_pkg.sv
// Shared types, widths and constants of the gesture rotate-to-zero block.
// Used by grz_ctrl, grz_dp and gesture_rotate_to_zero_top; no dependencies.
package grz_pkg;

   // Field widths of the request and response channels.
   localparam int PT_W  = 16;
   localparam int OUT_W = 17;

   // Coordinate sum width and the magnitude width that the divider works on.
   localparam int SUM_W = 23;
   localparam int MAG_W = SUM_W - 1;

   // CORDIC datapath: working width, guard bits, gain scaling.
   localparam int CW     = 40;
   localparam int GUARD  = 16;
   localparam int KSC    = 24;
   localparam int INVK_W = 24;
   localparam int LO_W   = 20;
   localparam int HI_W   = CW - LO_W;

   // Saturation bounds of the rotated coordinates.
   localparam int OUT_MAX = 65535;
   localparam int OUT_MIN = -65536;

   // Defaults of the top-level parameters.
   localparam int MAX_POINTS_DEF   = 64;
   localparam int CORDIC_STEPS_DEF = 16;

   // Controller states.
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_DIVI,
      ST_DIV,
      ST_CEN,
      ST_DIF,
      ST_VEC,
      ST_RD,
      ST_LD,
      ST_ROT,
      ST_MUL1,
      ST_MUL2,
      ST_FIN,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic clear;
      logic div_init;
      logic div_step;
      logic cen_set;
      logic dif_set;
      logic rd_en;
      logic v_load;
      logic cdc_step;
      logic vec_mode;
      logic mul1;
      logic mul2;
      logic fin;
      logic last_pt;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic d_zero;
   } status_type;

   // Gain of the vectoring CORDIC, scaled by 2^KSC, for a given step count.
   function automatic longint grz_kfix(input int steps);
      longint x;
      longint y;
      longint xs;
      longint ys;
      x = longint'(1) <<< KSC;
      y = 0;
      for (int i = 0; i < steps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
         end else begin
            x = x - ys;
            y = y + xs;
         end
      end
      return x;
   endfunction

endpackage

// File: src/gesture_rotate_to_zero_top.sv
// Top level of the gesture rotate-to-zero block.
// Depends on grz_pkg, grz_ctrl and grz_dp.
//
// Usage: points of one gesture path enter on the req_ channel, one request per
// cycle, while req_stall is low; req_last_point closes the path. Once that
// request is taken, req_stall stays high while the centroid is formed by a
// serial divider and the indicative angle by the shared CORDIC in vectoring
// mode. Each stored point then comes out on the rsp_ channel, in load order,
// rotated about the centroid: per point there is a store read, a load, the
// CORDIC rotation steps, gain removal in a low and a high partial product,
// rounding into the response register and the showing of the response;
// when the direction is zero the rotation and gain removal are skipped
// and the stored point passes through.
// Points beyond MAX_POINTS are dropped and rsp_overflowed is set on every
// response of that path; rsp_end_of_path marks the final response.
// While rsp_stall is high the response holds and the block waits. After the
// final response is taken the block accepts the next path.
// Reset (synchronous) empties the path and returns to accepting points.
module gesture_rotate_to_zero_top import grz_pkg::*; #(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [PT_W-1:0]  req_point_x,
   input  logic signed [PT_W-1:0]  req_point_y,
   input  logic                    req_last_point,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_aligned_x,
   output logic signed [OUT_W-1:0] rsp_aligned_y,
   output logic                    rsp_end_of_path,
   output logic                    rsp_overflowed
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int STEP_W = $clog2((CORDIC_STEPS > MAG_W ? CORDIC_STEPS : MAG_W) + 1);

   cmd_type           cmd;
   status_type        status;
   logic [CNT_W-1:0]  count;
   logic [ADDR_W-1:0] addr;
   logic [STEP_W-1:0] step;

   // Sequencing of load, centroid, angle and per-point rotation.
   grz_ctrl #(
      .MAX_POINTS   (MAX_POINTS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .count          (count),
      .status         (status),
      .cmd            (cmd),
      .addr           (addr),
      .step           (step)
   );

   // Store, arithmetic and response register.
   grz_dp #(
      .MAX_POINTS   (MAX_POINTS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .addr            (addr),
      .step            (step),
      .status          (status),
      .count           (count),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .rsp_aligned_x   (rsp_aligned_x),
      .rsp_aligned_y   (rsp_aligned_y),
      .rsp_end_of_path (rsp_end_of_path),
      .rsp_overflowed  (rsp_overflowed)
   );

endmodule

// File: src/grz_ctrl.sv
// Controller state machine of the gesture rotate-to-zero block.
// Depends on grz_pkg; drives the command struct of grz_dp.
module grz_ctrl import grz_pkg::*; #(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_last_point,
   output logic                                  req_stall,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [$clog2(MAX_POINTS+1)-1:0]       count,
   input  status_type                            status,
   output cmd_type                               cmd,
   output logic [$clog2(MAX_POINTS)-1:0]         addr,
   output logic [$clog2((CORDIC_STEPS > MAG_W ? CORDIC_STEPS : MAG_W) + 1)-1:0] step
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int STEP_W = $clog2((CORDIC_STEPS > MAG_W ? CORDIC_STEPS : MAG_W) + 1);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic                last_idx;
   logic                div_done;
   logic                cdc_done;

   assign last_idx = (CNT_W'(idx_ff) + CNT_W'(1)) == count;
   assign div_done = step_ff == STEP_W'(MAG_W - 1);
   assign cdc_done = step_ff == STEP_W'(CORDIC_STEPS - 1);

   // State register and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         step_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: if (req_valid && req_last_point) state_in = ST_DIVI;
         ST_DIVI: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_CEN;
         ST_CEN:  state_in = ST_DIF;
         ST_DIF:  state_in = ST_VEC;
         ST_VEC:  if (cdc_done) state_in = ST_RD;
         ST_RD:   state_in = ST_LD;
         ST_LD:   state_in = status.d_zero ? ST_FIN : ST_ROT;
         ST_ROT:  if (cdc_done) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_FIN;
         ST_FIN:  state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) state_in = last_idx ? ST_LOAD : ST_RD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs, commands and counter updates.
   always_comb begin
      cmd       = '0;
      step_in   = step_ff;
      idx_in    = idx_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      addr      = idx_ff;
      cmd.last_pt = last_idx;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            step_in   = '0;
            idx_in    = '0;
         end
         ST_DIVI: cmd.div_init = 1'b1;
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = div_done ? '0 : step_ff + STEP_W'(1);
         end
         ST_CEN: begin
            cmd.cen_set = 1'b1;
            cmd.rd_en   = 1'b1;
            addr        = '0;
         end
         ST_DIF: cmd.dif_set = 1'b1;
         ST_VEC: begin
            cmd.cdc_step = 1'b1;
            cmd.vec_mode = 1'b1;
            step_in      = cdc_done ? '0 : step_ff + STEP_W'(1);
         end
         ST_RD:  cmd.rd_en = 1'b1;
         ST_LD:  cmd.v_load = 1'b1;
         ST_ROT: begin
            cmd.cdc_step = 1'b1;
            step_in      = cdc_done ? '0 : step_ff + STEP_W'(1);
         end
         ST_MUL1: cmd.mul1 = 1'b1;
         ST_MUL2: cmd.mul2 = 1'b1;
         ST_FIN:  cmd.fin = 1'b1;
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.clear = last_idx;
               idx_in    = last_idx ? '0 : idx_ff + ADDR_W'(1);
            end
         end
         default: ;
      endcase
   end

   assign step = step_ff;

   // The block returns to loading once the final point has been taken.
   a_end_to_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_stall && last_idx) |=> state_ff == ST_LOAD)
      else $error("block did not return to loading after the final point");

   // A shown point always lies inside the loaded path.
   a_idx_in_path: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> CNT_W'(idx_ff) < count)
      else $error("point index beyond point count");

   // CORDIC step counter stays within the configured number of steps.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VEC || state_ff == ST_ROT) |-> step_ff < STEP_W'(CORDIC_STEPS))
      else $error("CORDIC step counter out of range");

endmodule

// File: src/grz_dp.sv
// Datapath of the gesture rotate-to-zero block: point store, sums, centroid
// divider, shared CORDIC, gain multiplier and response register. Uses grz_pkg.
module grz_dp import grz_pkg::*; #(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cmd_type                               cmd,
   input  logic [$clog2(MAX_POINTS)-1:0]         addr,
   input  logic [$clog2((CORDIC_STEPS > MAG_W ? CORDIC_STEPS : MAG_W) + 1)-1:0] step,
   output status_type                            status,
   output logic [$clog2(MAX_POINTS+1)-1:0]       count,
   input  logic signed [PT_W-1:0]                req_point_x,
   input  logic signed [PT_W-1:0]                req_point_y,
   output logic signed [OUT_W-1:0]               rsp_aligned_x,
   output logic signed [OUT_W-1:0]               rsp_aligned_y,
   output logic                                  rsp_end_of_path,
   output logic                                  rsp_overflowed
);

   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W  = $clog2(MAX_POINTS);
   localparam int CIDX_W  = $clog2(CORDIC_STEPS);
   localparam int D_W     = PT_W + 1;
   localparam int PW      = CW + INVK_W + 1;
   localparam int PLO_W   = LO_W + INVK_W;
   localparam int PHI_W   = HI_W + INVK_W + 1;
   localparam int SHR     = GUARD + KSC;
   localparam int Q_W     = PW - SHR;
   localparam int S_W     = Q_W + 1;
   localparam longint KFIX    = grz_kfix(CORDIC_STEPS);
   localparam longint INV_K_L = (longint'(1) <<< (2 * KSC)) / KFIX;
   localparam logic [INVK_W-1:0] INV_K = INVK_W'(INV_K_L);

   // Point store.
   logic [PT_W-1:0] mem_x [MAX_POINTS];
   logic [PT_W-1:0] mem_y [MAX_POINTS];
   logic signed [PT_W-1:0] rd_x_ff, rd_y_ff;

   // Path accumulation.
   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    drop_ff;
   logic                    has_room;

   // Divider.
   logic [MAG_W-1:0] mag_x_ff, mag_y_ff;
   logic [CNT_W-1:0] rem_x_ff, rem_y_ff;
   logic             neg_x_ff, neg_y_ff;
   logic [CNT_W:0]   rs_x, rs_y;
   logic             ge_x, ge_y;

   // Centroid, direction and CORDIC.
   logic signed [PT_W-1:0] cx_ff, cy_ff;
   logic                   flip_ff, dzero_ff;
   logic signed [D_W-1:0]  dx, dy, dxf, dyf, vx, vy, vxf, vyf;
   logic signed [CW-1:0]   x_ff, y_ff, xs, ys;
   logic [CORDIC_STEPS-1:0] dir_ff;
   logic                   dir_now;

   // Gain removal and response.
   logic [PLO_W-1:0]        plo_x_ff, plo_y_ff;
   logic signed [PHI_W-1:0] phi_x, phi_y;
   logic signed [PW-1:0]    prod_x_ff, prod_y_ff, rnd_x, rnd_y;
   logic signed [S_W-1:0]   s_x, s_y;
   logic signed [OUT_W-1:0] sat_x, sat_y;
   logic signed [OUT_W-1:0] out_x_ff, out_y_ff;
   logic                    eop_ff, ovf_ff;

   assign has_room = cnt_ff < CNT_W'(MAX_POINTS);

   // Store writes at the fill position; reads are registered.
   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         mem_x[cnt_ff[ADDR_W-1:0]] <= req_point_x;
         mem_y[cnt_ff[ADDR_W-1:0]] <= req_point_y;
      end
      if (cmd.rd_en) begin
         rd_x_ff <= mem_x[addr];
         rd_y_ff <= mem_y[addr];
      end
   end

   // Sums, count and drop flag of the current path.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
      end else if (cmd.load) begin
         if (has_room) begin
            sum_x_ff <= sum_x_ff + SUM_W'(req_point_x);
            sum_y_ff <= sum_y_ff + SUM_W'(req_point_y);
            cnt_ff   <= cnt_ff + CNT_W'(1);
         end else begin
            drop_ff <= 1'b1;
         end
      end
   end

   // Restoring divider step on both sum magnitudes.
   always_comb begin
      rs_x = {rem_x_ff, mag_x_ff[MAG_W-1]};
      rs_y = {rem_y_ff, mag_y_ff[MAG_W-1]};
      ge_x = rs_x >= {1'b0, cnt_ff};
      ge_y = rs_y >= {1'b0, cnt_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         mag_x_ff <= sum_x_ff[SUM_W-1] ? MAG_W'(-sum_x_ff) : MAG_W'(sum_x_ff);
         mag_y_ff <= sum_y_ff[SUM_W-1] ? MAG_W'(-sum_y_ff) : MAG_W'(sum_y_ff);
         neg_x_ff <= sum_x_ff[SUM_W-1];
         neg_y_ff <= sum_y_ff[SUM_W-1];
         rem_x_ff <= '0;
         rem_y_ff <= '0;
      end else if (cmd.div_step) begin
         rem_x_ff <= ge_x ? CNT_W'(rs_x - {1'b0, cnt_ff}) : rs_x[CNT_W-1:0];
         rem_y_ff <= ge_y ? CNT_W'(rs_y - {1'b0, cnt_ff}) : rs_y[CNT_W-1:0];
         mag_x_ff <= {mag_x_ff[MAG_W-2:0], ge_x};
         mag_y_ff <= {mag_y_ff[MAG_W-2:0], ge_y};
      end
   end

   // Direction from the first point to the centroid, and point offsets.
   always_comb begin
      dx  = D_W'(cx_ff) - D_W'(rd_x_ff);
      dy  = D_W'(cy_ff) - D_W'(rd_y_ff);
      dxf = dx[D_W-1] ? -dx : dx;
      dyf = dx[D_W-1] ? -dy : dy;
      vx  = D_W'(rd_x_ff) - D_W'(cx_ff);
      vy  = D_W'(rd_y_ff) - D_W'(cy_ff);
      vxf = flip_ff ? -vx : vx;
      vyf = flip_ff ? -vy : vy;
   end

   // Shared CORDIC micro-rotation; vectoring records the directions.
   always_comb begin
      xs      = x_ff >>> step;
      ys      = y_ff >>> step;
      dir_now = cmd.vec_mode ? !y_ff[CW-1] : dir_ff[step[CIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.cen_set) begin
         cx_ff <= neg_x_ff ? -mag_x_ff[PT_W-1:0] : mag_x_ff[PT_W-1:0];
         cy_ff <= neg_y_ff ? -mag_y_ff[PT_W-1:0] : mag_y_ff[PT_W-1:0];
      end
      if (cmd.dif_set) begin
         flip_ff  <= dx[D_W-1];
         dzero_ff <= (dx == '0) && (dy == '0);
         x_ff     <= CW'(dxf) <<< GUARD;
         y_ff     <= CW'(dyf) <<< GUARD;
      end else if (cmd.v_load) begin
         x_ff <= CW'(vxf) <<< GUARD;
         y_ff <= CW'(vyf) <<< GUARD;
      end else if (cmd.cdc_step) begin
         if (cmd.vec_mode) dir_ff[step[CIDX_W-1:0]] <= dir_now;
         x_ff <= dir_now ? x_ff + ys : x_ff - ys;
         y_ff <= dir_now ? y_ff - xs : y_ff + xs;
      end
   end

   // Gain removal, split into a low and a high partial product.
   always_comb begin
      phi_x = $signed(x_ff[CW-1:LO_W]) * $signed({1'b0, INV_K});
      phi_y = $signed(y_ff[CW-1:LO_W]) * $signed({1'b0, INV_K});
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         plo_x_ff <= PLO_W'(x_ff[LO_W-1:0]) * PLO_W'(INV_K);
         plo_y_ff <= PLO_W'(y_ff[LO_W-1:0]) * PLO_W'(INV_K);
      end
      if (cmd.mul2) begin
         prod_x_ff <= (PW'(phi_x) <<< LO_W) + PW'(plo_x_ff);
         prod_y_ff <= (PW'(phi_y) <<< LO_W) + PW'(plo_y_ff);
      end
   end

   // Round to nearest, move back by the centroid and saturate.
   always_comb begin
      rnd_x = prod_x_ff + (PW'(1) <<< (SHR - 1));
      rnd_y = prod_y_ff + (PW'(1) <<< (SHR - 1));
      s_x   = S_W'($signed(rnd_x[PW-1:SHR])) + S_W'(cx_ff);
      s_y   = S_W'($signed(rnd_y[PW-1:SHR])) + S_W'(cy_ff);
      if (s_x > S_W'(OUT_MAX))      sat_x = OUT_W'(OUT_MAX);
      else if (s_x < S_W'(OUT_MIN)) sat_x = OUT_W'(OUT_MIN);
      else                          sat_x = OUT_W'(s_x);
      if (s_y > S_W'(OUT_MAX))      sat_y = OUT_W'(OUT_MAX);
      else if (s_y < S_W'(OUT_MIN)) sat_y = OUT_W'(OUT_MIN);
      else                          sat_y = OUT_W'(s_y);
   end

   // Response register; a zero direction passes the stored point through.
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         out_x_ff <= dzero_ff ? OUT_W'(rd_x_ff) : sat_x;
         out_y_ff <= dzero_ff ? OUT_W'(rd_y_ff) : sat_y;
         eop_ff   <= cmd.last_pt;
         ovf_ff   <= drop_ff;
      end
   end

   assign status.d_zero   = dzero_ff;
   assign count           = cnt_ff;
   assign rsp_aligned_x   = out_x_ff;
   assign rsp_aligned_y   = out_y_ff;
   assign rsp_end_of_path = eop_ff;
   assign rsp_overflowed  = ovf_ff;

   // The fill count never passes the store size.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store size");

   // A request taken while the store is full raises the drop flag.
   a_drop_set: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !has_room && !cmd.clear) |=> drop_ff)
      else $error("dropped point not flagged");

   // Finishing a path leaves an empty, unflagged accumulator.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (cnt_ff == '0 && !drop_ff && sum_x_ff == '0 && sum_y_ff == '0))
      else $error("path state not cleared");

endmodule
